// File: src/chps_pkg.sv
// Shared types, constants and register indexes for the channel peak hold smoother.
package chps_pkg;

    localparam int CHANNEL_COUNT = 79;
    localparam int ADDR_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_EMITTER_DELTA = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FLASH_LENGTH  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_MS       = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_STEP_MS = 8'd3;

    localparam logic [7:0]  EMITTER_DELTA_RESET = 8'd8;
    localparam logic [3:0]  FLASH_LENGTH_RESET  = 4'd3;
    localparam logic [15:0] HOLD_MS_RESET       = 16'd600;
    localparam logic [15:0] DECAY_STEP_RESET    = 16'd200;

    typedef struct packed {
        logic [7:0]  smoothed;
        logic [7:0]  peak;
        logic [31:0] peak_time;
        logic [3:0]  flash;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [7:0]  emitter_delta;
        logic [3:0]  flash_length;
        logic [15:0] hold_ms;
        logic [15:0] decay_step_ms;
    } cfg_t;

endpackage

// File: src/chps_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module chps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/chps_update.sv
// Per-channel update of smoothed value, flash counter and decaying peak.
module chps_update (
    input  chps_pkg::entry_t old_entry,
    input  logic [7:0]       sample,
    input  logic [31:0]      now_ms,
    input  chps_pkg::cfg_t   cfg,
    output chps_pkg::entry_t new_entry,
    output logic             fresh
);

    logic [8:0]  rise_limit;
    logic [9:0]  blend;
    logic [16:0] decay_limit;
    logic [31:0] elapsed;
    logic [31:0] decay_time;
    logic        decay;
    logic [3:0]  flash_dec;

    always_comb
    begin
        rise_limit  = {1'b0, old_entry.smoothed} + {1'b0, cfg.emitter_delta};
        fresh       = {1'b0, sample} > rise_limit;
        blend       = {1'b0, old_entry.smoothed, 1'b0} + {2'b00, old_entry.smoothed}
                      + {2'b00, sample};
        decay_limit = {1'b0, cfg.hold_ms} + {1'b0, cfg.decay_step_ms};
        elapsed     = now_ms - old_entry.peak_time;
        decay_time  = now_ms - {16'd0, cfg.hold_ms};
        decay       = elapsed > {15'd0, decay_limit};
        flash_dec   = (old_entry.flash != 4'd0) ? old_entry.flash - 4'd1 : 4'd0;

        new_entry = old_entry;

        if (sample > old_entry.smoothed)
        begin
            new_entry.smoothed = sample;
        end
        else
        begin
            new_entry.smoothed = blend[9:2];
        end

        new_entry.flash = fresh ? cfg.flash_length : flash_dec;

        if (sample > old_entry.peak)
        begin
            new_entry.peak      = sample;
            new_entry.peak_time = now_ms;
        end
        else if (decay)
        begin
            if (old_entry.peak != 8'd0)
            begin
                new_entry.peak = old_entry.peak - 8'd1;
            end
            new_entry.peak_time = decay_time;
        end
    end

endmodule

// File: src/channel_peak_hold_smoother.sv
// Top level: per-channel peak hold and smoothing around one state memory.
// Pipeline: an accepted request passes the s1 stage, then the output registers.
// Throughput: one request per cycle unless out_ready stalls; the memory read and
// the previous write-back overlap, and a same-channel neighbor is forwarded.
// Reset: configuration registers return to their defaults and per-channel valid
// flags clear, so every channel reads as zero at once with no clearing pass.
module channel_peak_hold_smoother (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [chps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [15:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [6:0]                         channel,
    input  logic [7:0]                         sample,
    input  logic [31:0]                        now_ms,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [6:0]                         channel_out,
    output logic [7:0]                         smoothed,
    output logic [7:0]                         peak,
    output logic [3:0]                         flash_count,
    output logic                               new_emitter
);

    chps_pkg::cfg_t cfg_reg;

    logic                           accept;
    logic                           in_range;
    logic [chps_pkg::ADDR_W-1:0]    rd_addr;
    logic [chps_pkg::ADDR_W-1:0]    wr_addr;
    logic                           s1_adv;
    logic                           fwd_hit;
    logic                           ram_we;
    logic [chps_pkg::ENTRY_W-1:0]   ram_rdata;
    chps_pkg::entry_t               old_entry;
    chps_pkg::entry_t               upd_entry;
    logic                           upd_fresh;

    logic [chps_pkg::CHANNEL_COUNT-1:0] valid_reg;

    logic                           s1_valid_reg;
    logic                           s1_inrange_reg;
    logic                           s1_init_reg;
    logic [6:0]                     s1_channel_reg;
    logic [7:0]                     s1_sample_reg;
    logic [31:0]                    s1_now_reg;
    logic                           fwd_hit_reg;
    chps_pkg::entry_t               fwd_entry_reg;

    logic                           out_valid_reg;
    logic [6:0]                     channel_out_reg;
    logic [7:0]                     smoothed_reg;
    logic [7:0]                     peak_reg;
    logic [3:0]                     flash_count_reg;
    logic                           new_emitter_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.emitter_delta <= chps_pkg::EMITTER_DELTA_RESET;
            cfg_reg.flash_length  <= chps_pkg::FLASH_LENGTH_RESET;
            cfg_reg.hold_ms       <= chps_pkg::HOLD_MS_RESET;
            cfg_reg.decay_step_ms <= chps_pkg::DECAY_STEP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                chps_pkg::REG_EMITTER_DELTA: cfg_reg.emitter_delta <= cfg_data[7:0];
                chps_pkg::REG_FLASH_LENGTH:  cfg_reg.flash_length  <= cfg_data[3:0];
                chps_pkg::REG_HOLD_MS:       cfg_reg.hold_ms       <= cfg_data;
                chps_pkg::REG_DECAY_STEP_MS: cfg_reg.decay_step_ms <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;
    assign in_range = 32'(channel) < chps_pkg::CHANNEL_COUNT;
    assign rd_addr  = chps_pkg::ADDR_W'(channel);
    assign wr_addr  = chps_pkg::ADDR_W'(s1_channel_reg);
    assign ram_we   = s1_valid_reg && s1_inrange_reg && s1_adv;
    assign fwd_hit  = ram_we && (s1_channel_reg == channel);

    chps_ram #(
        .WIDTH (chps_pkg::ENTRY_W),
        .DEPTH (chps_pkg::CHANNEL_COUNT)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (upd_entry),
        .re    (accept && in_range),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            old_entry = fwd_entry_reg;
        end
        else if (s1_init_reg)
        begin
            old_entry = chps_pkg::entry_t'(ram_rdata);
        end
        else
        begin
            old_entry = '0;
        end
    end

    chps_update u_update (
        .old_entry (old_entry),
        .sample    (s1_sample_reg),
        .now_ms    (s1_now_reg),
        .cfg       (cfg_reg),
        .new_entry (upd_entry),
        .fresh     (upd_fresh)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_channel_reg <= channel;
            s1_sample_reg  <= sample;
            s1_now_reg     <= now_ms;
            s1_inrange_reg <= in_range;
            s1_init_reg    <= in_range && valid_reg[rd_addr];
            fwd_hit_reg    <= fwd_hit;
            fwd_entry_reg  <= upd_entry;
        end
        if (s1_adv && s1_valid_reg)
        begin
            channel_out_reg <= s1_channel_reg;
            if (s1_inrange_reg)
            begin
                smoothed_reg    <= upd_entry.smoothed;
                peak_reg        <= upd_entry.peak;
                flash_count_reg <= upd_entry.flash;
                new_emitter_reg <= upd_fresh;
            end
            else
            begin
                smoothed_reg    <= 8'd0;
                peak_reg        <= 8'd0;
                flash_count_reg <= 4'd0;
                new_emitter_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign channel_out = channel_out_reg;
    assign smoothed    = smoothed_reg;
    assign peak        = peak_reg;
    assign flash_count = flash_count_reg;
    assign new_emitter = new_emitter_reg;

    a_fwd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && fwd_hit_reg |-> s1_inrange_reg)
        else $error("forwarded entry on an out-of-range request");

    a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> s1_valid_reg && s1_inrange_reg && s1_adv)
        else $error("state write without a valid in-range request");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_adv |=> out_valid_reg)
        else $error("advanced request produced no result");

    a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> valid_reg[$past(wr_addr)])
        else $error("written channel not marked valid");

endmodule
